// ===== design/limit_order_book_matcher_unit_macros.svh =====
// Assertion macros used by the order book matcher unit.
`ifndef LIMIT_ORDER_BOOK_MATCHER_UNIT_MACROS_SVH
`define LIMIT_ORDER_BOOK_MATCHER_UNIT_MACROS_SVH

// Same-cycle implication under the block reset.
`define LOBM_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication under the block reset.
`define LOBM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/lobm_pkg.sv =====
// Types, constants and helper functions of the order book matcher.
package lobm_pkg;

    localparam int unsigned PRICE_W = 30;
    localparam int unsigned AMT_W   = 30;
    localparam logic [AMT_W-1:0] MOD_P = 30'd1000000007;

    typedef struct packed {
        logic [PRICE_W-1:0] price;
        logic [AMT_W-1:0]   amount;
        logic               side;
    } order_t;

    typedef struct packed {
        logic [AMT_W-1:0] matched_amount;
        logic [AMT_W-1:0] backlog_mod;
        logic             dropped;
    } result_t;

    typedef struct packed {
        logic [PRICE_W-1:0] price;
        logic [AMT_W-1:0]   amount;
    } entry_t;

    typedef struct packed {
        logic   pop;
        logic   push;
        entry_t entry;
    } book_cmd_t;

    // True when a ranks ahead of b in its book.
    function automatic logic ahead(input logic sell, input entry_t a, input entry_t b);
        logic r;
        if (a.price != b.price)
        begin
            r = sell ? (a.price < b.price) : (a.price > b.price);
        end
        else
        begin
            r = sell ? (a.amount < b.amount) : (a.amount > b.amount);
        end
        return r;
    endfunction

    function automatic logic [AMT_W-1:0] mod_reduce(input logic [AMT_W-1:0] x);
        logic [AMT_W-1:0] r;
        r = (x >= MOD_P) ? (x - MOD_P) : x;
        return r;
    endfunction

endpackage

// ===== design/lobm_cell.sv =====
// One slot of a sorted book: holds an entry and shifts with its neighbors.
module lobm_cell #(
    parameter bit SELL  = 1'b0,
    parameter bit FIRST = 1'b0
) (
    input  logic              clk,
    input  lobm_pkg::book_cmd_t cmd,
    input  logic              free,
    input  lobm_pkg::entry_t  left,
    input  logic              left_lead,
    input  lobm_pkg::entry_t  right,
    output lobm_pkg::entry_t  entry,
    output logic              lead
);

    lobm_pkg::entry_t entry_reg;
    lobm_pkg::entry_t entry_next;

    assign lead  = free || lobm_pkg::ahead(SELL, cmd.entry, entry_reg);
    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.pop)
        begin
            entry_next = right;
        end
        else if (cmd.push && lead)
        begin
            // Take the neighbor's entry unless the new one lands here.
            entry_next = (!FIRST && left_lead) ? left : cmd.entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

// ===== design/lobm_book.sv =====
// One side of the book: a sorted row of cells with its fill count.
module lobm_book #(
    parameter int unsigned DEPTH = 1024,
    parameter bit          SELL  = 1'b0
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  lobm_pkg::book_cmd_t        cmd,
    output lobm_pkg::entry_t           head,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    lobm_pkg::entry_t entries [DEPTH];
    logic             leads [DEPTH];

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            lobm_pkg::entry_t left_e;
            lobm_pkg::entry_t right_e;
            logic             left_b;
            if (i == 0)
            begin : g_first
                assign left_e = '0;
                assign left_b = 1'b0;
            end
            else
            begin : g_mid
                assign left_e = entries[i-1];
                assign left_b = leads[i-1];
            end
            if (i == DEPTH - 1)
            begin : g_last
                assign right_e = '0;
            end
            else
            begin : g_inner
                assign right_e = entries[i+1];
            end
            lobm_cell #(
                .SELL  (SELL),
                .FIRST (i == 0)
            ) u_cell (
                .clk       (clk),
                .cmd       (cmd),
                .free      (CNT_W'(i) >= count_reg),
                .left      (left_e),
                .left_lead (left_b),
                .right     (right_e),
                .entry     (entries[i]),
                .lead      (leads[i])
            );
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        if (cmd.pop)
        begin
            count_next = count_reg - CNT_W'(1);
        end
        else if (cmd.push)
        begin
            count_next = count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign head  = entries[0];
    assign count = count_reg;

endmodule

// ===== design/limit_order_book_matcher_unit.sv =====
// Order book matcher: a start is taken while busy is low and, once the
// order is done, result is shown for one cycle with strobe high; the receiver
// cannot stall it. Each book is a row of cells kept sorted best first, so the
// best entry is always in the first cell. The match loop takes one resting
// entry per cycle; a last entry that is only partly used is put back in
// order in its book. The result strobes in the cycle busy falls. No
// clearing pass is needed after reset.
`include "limit_order_book_matcher_unit_macros.svh"

module limit_order_book_matcher_unit #(
    parameter int unsigned BOOK_DEPTH = 1024
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  lobm_pkg::order_t  order,
    output logic              strobe,
    output lobm_pkg::result_t result
);

    localparam int unsigned CNT_W = $clog2(BOOK_DEPTH + 1);
    localparam int unsigned AW    = lobm_pkg::AMT_W;

    typedef enum logic [4:0] {
        IDLE  = 5'b00001,
        MATCH = 5'b00010,
        REINS = 5'b00100,
        REST  = 5'b01000,
        SPARE = 5'b10000
    } state_t;

    state_t                      state_reg, state_next;
    logic [lobm_pkg::PRICE_W-1:0] price_reg, price_next;
    logic [AW-1:0]               amt_reg, amt_next;
    logic                        side_reg, side_next;
    logic [AW-1:0]               matched_reg, matched_next;
    logic [AW-1:0]               backlog_reg, backlog_next;
    lobm_pkg::entry_t            rein_reg, rein_next;
    lobm_pkg::result_t           result_reg, result_next;
    logic                        strobe_reg, strobe_next;

    lobm_pkg::book_cmd_t buy_cmd, sell_cmd, opp_cmd, own_cmd;
    lobm_pkg::entry_t    buy_head, sell_head, opp_head;
    logic [CNT_W-1:0]    buy_count, sell_count, opp_count, own_count;

    logic          crosses;
    logic [AW-1:0] take;
    logic [AW-1:0] take_r;
    logic [AW:0]   diff;
    logic [AW-1:0] rest_r;
    logic [AW:0]   sum;

    lobm_book #(.DEPTH(BOOK_DEPTH), .SELL(1'b0)) u_buy (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (buy_cmd),
        .head  (buy_head),
        .count (buy_count)
    );

    lobm_book #(.DEPTH(BOOK_DEPTH), .SELL(1'b1)) u_sell (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (sell_cmd),
        .head  (sell_head),
        .count (sell_count)
    );

    assign opp_head  = side_reg ? buy_head : sell_head;
    assign opp_count = side_reg ? buy_count : sell_count;
    assign own_count = side_reg ? sell_count : buy_count;
    assign buy_cmd   = side_reg ? opp_cmd : own_cmd;
    assign sell_cmd  = side_reg ? own_cmd : opp_cmd;

    assign crosses = side_reg ? (opp_head.price >= price_reg) : (opp_head.price <= price_reg);
    assign take    = (opp_head.amount > amt_reg) ? amt_reg : opp_head.amount;

    // Modular subtract of the matched units and add of the resting remainder.
    assign take_r = lobm_pkg::mod_reduce(take);
    assign diff   = {1'b0, backlog_reg} - {1'b0, take_r};
    assign rest_r = lobm_pkg::mod_reduce(amt_reg);
    assign sum    = {1'b0, backlog_reg} + {1'b0, rest_r};

    always_comb
    begin
        state_next   = state_reg;
        price_next   = price_reg;
        amt_next     = amt_reg;
        side_next    = side_reg;
        matched_next = matched_reg;
        backlog_next = backlog_reg;
        rein_next    = rein_reg;
        result_next  = result_reg;
        strobe_next  = 1'b0;
        opp_cmd      = '0;
        own_cmd      = '0;
        unique case (state_reg)
            IDLE:
            begin
                if (start)
                begin
                    price_next   = order.price;
                    amt_next     = order.amount;
                    side_next    = order.side;
                    matched_next = '0;
                    state_next   = MATCH;
                end
            end
            MATCH:
            begin
                if (amt_reg == '0 || opp_count == '0 || !crosses)
                begin
                    state_next = REST;
                end
                else
                begin
                    opp_cmd.pop  = 1'b1;
                    matched_next = matched_reg + take;
                    amt_next     = amt_reg - take;
                    backlog_next = diff[AW] ? (diff[AW-1:0] + lobm_pkg::MOD_P)
                                            : diff[AW-1:0];
                    if (opp_head.amount > amt_reg)
                    begin
                        rein_next.price  = opp_head.price;
                        rein_next.amount = opp_head.amount - amt_reg;
                        state_next       = REINS;
                    end
                end
            end
            REINS:
            begin
                // Put the partly used entry back in its sorted place.
                opp_cmd.push  = 1'b1;
                opp_cmd.entry = rein_reg;
                state_next    = REST;
            end
            REST:
            begin
                result_next.dropped = 1'b0;
                if (amt_reg != '0)
                begin
                    if (own_count < CNT_W'(BOOK_DEPTH))
                    begin
                        own_cmd.push         = 1'b1;
                        own_cmd.entry.price  = price_reg;
                        own_cmd.entry.amount = amt_reg;
                        backlog_next = (sum >= {1'b0, lobm_pkg::MOD_P})
                                       ? AW'(sum - {1'b0, lobm_pkg::MOD_P}) : sum[AW-1:0];
                    end
                    else
                    begin
                        result_next.dropped = 1'b1;
                    end
                end
                result_next.matched_amount = matched_reg;
                result_next.backlog_mod    = backlog_next;
                strobe_next                = 1'b1;
                state_next                 = IDLE;
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= IDLE;
            backlog_reg <= '0;
            strobe_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            backlog_reg <= backlog_next;
            strobe_reg  <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        price_reg   <= price_next;
        amt_reg     <= amt_next;
        side_reg    <= side_next;
        matched_reg <= matched_next;
        rein_reg    <= rein_next;
        result_reg  <= result_next;
    end

    assign busy   = (state_reg != IDLE);
    assign strobe = strobe_reg;
    assign result = result_reg;

    `LOBM_ASSERT_NEXT(a_start_busy, start && !busy, busy, "accepted item did not raise busy")
    `LOBM_ASSERT_IMPLY(a_strobe_idle, strobe, !busy, "result shown while still busy")
    `LOBM_ASSERT_IMPLY(a_buy_fill, 1'b1, buy_count <= CNT_W'(BOOK_DEPTH), "buy book overfilled")
    `LOBM_ASSERT_IMPLY(a_sell_fill, 1'b1, sell_count <= CNT_W'(BOOK_DEPTH), "sell book overfilled")

endmodule

// ===== tb/limit_order_book_matcher_unit_test.sv =====
// Testbench of the order book matcher: random and directed orders checked against a model.
`timescale 1ns / 1ps

module limit_order_book_matcher_unit_test;

    localparam int unsigned DEPTH = 1024;
    localparam longint unsigned PRIME = 64'd1000000007;
    localparam logic SIDE_BUY = 1'b0;
    localparam logic SIDE_SELL = 1'b1;

    int errors = 0;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d want %0d", what, got, want);
        errors++;
    endtask

    class order_book_scoreboard;
        lobm_pkg::entry_t buy_book[$];
        lobm_pkg::entry_t sell_book[$];
        longint unsigned backlog;
        lobm_pkg::result_t pending[$];

        function int best_index(ref lobm_pkg::entry_t bk[$], input logic sell);
            int b;
            b = 0;
            for (int i = 1; i < bk.size(); i++)
            begin
                if (bk[i].price != bk[b].price)
                begin
                    if (sell ? (bk[i].price > bk[b].price) : (bk[i].price < bk[b].price))
                        b = i;
                end
                else if (sell ? (bk[i].amount > bk[b].amount)
                              : (bk[i].amount < bk[b].amount))
                    b = i;
            end
            return b;
        endfunction

        function void note_order(input lobm_pkg::order_t o);
            logic [29:0] left;
            logic [29:0] matched;
            logic dropped;
            int i;
            lobm_pkg::result_t r;
            left = o.amount;
            matched = '0;
            dropped = 1'b0;
            if (o.side == SIDE_SELL)
            begin
                while (left > 0 && buy_book.size() > 0)
                begin
                    i = best_index(buy_book, 1'b1);
                    if (buy_book[i].price < o.price)
                        break;
                    if (buy_book[i].amount > left)
                    begin
                        buy_book[i].amount -= left;
                        matched += left;
                        backlog -= left;
                        left = 0;
                    end
                    else
                    begin
                        matched += buy_book[i].amount;
                        left -= buy_book[i].amount;
                        backlog -= buy_book[i].amount;
                        buy_book.delete(i);
                    end
                end
                if (left > 0)
                begin
                    if (sell_book.size() < DEPTH)
                    begin
                        sell_book.push_back('{o.price, left});
                        backlog += left;
                    end
                    else
                        dropped = 1'b1;
                end
            end
            else
            begin
                while (left > 0 && sell_book.size() > 0)
                begin
                    i = best_index(sell_book, 1'b0);
                    if (sell_book[i].price > o.price)
                        break;
                    if (sell_book[i].amount > left)
                    begin
                        sell_book[i].amount -= left;
                        matched += left;
                        backlog -= left;
                        left = 0;
                    end
                    else
                    begin
                        matched += sell_book[i].amount;
                        left -= sell_book[i].amount;
                        backlog -= sell_book[i].amount;
                        sell_book.delete(i);
                    end
                end
                if (left > 0)
                begin
                    if (buy_book.size() < DEPTH)
                    begin
                        buy_book.push_back('{o.price, left});
                        backlog += left;
                    end
                    else
                        dropped = 1'b1;
                end
            end
            r.matched_amount = matched;
            r.backlog_mod = 30'(backlog % PRIME);
            r.dropped = dropped;
            pending.push_back(r);
        endfunction

        task check_result(input lobm_pkg::result_t got);
            lobm_pkg::result_t want;
            if (pending.size() == 0)
            begin
                report_mismatch("unexpected result", 0, 1);
                return;
            end
            want = pending.pop_front();
            if (got.matched_amount !== want.matched_amount)
                report_mismatch("matched_amount", got.matched_amount, want.matched_amount);
            if (got.backlog_mod !== want.backlog_mod)
                report_mismatch("backlog_mod", got.backlog_mod, want.backlog_mod);
            if (got.dropped !== want.dropped)
                report_mismatch("dropped", got.dropped, want.dropped);
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    lobm_pkg::order_t order = '0;
    logic strobe;
    lobm_pkg::result_t result;

    order_book_scoreboard books = new();
    int burst_left = 0;

    limit_order_book_matcher_unit #(.BOOK_DEPTH(DEPTH)) dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .order(order), .strobe(strobe), .result(result)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && strobe)
            books.check_result(result);
    end

    // Drive one order; hold start until the block takes it.
    task automatic send_order(input logic [29:0] p, input logic [29:0] a, input logic s);
        lobm_pkg::order_t o;
        int gap;
        o.price = p;
        o.amount = a;
        o.side = s;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 6);
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        start <= 1'b1;
        order <= o;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        books.note_order(o);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (books.pending.size() != 0)
            @(posedge clk);
    endtask

    // Mostly near prices so orders cross; a few extremes.
    function automatic logic [29:0] pick_price();
        case ($urandom_range(0, 9))
            0: return 30'($urandom);
            1: return 30'h3FFFFFFF;
            2: return 30'd1;
            default: return 30'($urandom_range(500, 540));
        endcase
    endfunction

    function automatic logic [29:0] pick_amount();
        case ($urandom_range(0, 9))
            0: return 30'($urandom);
            1: return 30'd1000000000;
            2: return 30'h3FFFFFFF;
            default: return 30'($urandom_range(1, 50));
        endcase
    endfunction

    initial
    begin
        #400000;
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // zero amount on empty books, then extremes
        send_order(30'd100, 30'd0, SIDE_BUY);
        send_order(30'h3FFFFFFF, 30'h3FFFFFFF, SIDE_BUY);
        send_order(30'd0, 30'h3FFFFFFF, SIDE_SELL);
        send_order(30'd1, 30'd1, SIDE_SELL);
        // equal prices with different amounts on both sides
        send_order(30'd50, 30'd10, SIDE_SELL);
        send_order(30'd50, 30'd5, SIDE_SELL);
        send_order(30'd50, 30'd20, SIDE_SELL);
        send_order(30'd50, 30'd7, SIDE_BUY);
        send_order(30'd50, 30'd30, SIDE_BUY);
        send_order(30'd40, 30'd3, SIDE_BUY);
        send_order(30'd40, 30'd9, SIDE_BUY);
        send_order(30'd40, 30'd4, SIDE_SELL);
        send_order(30'd10, 30'd100, SIDE_SELL);
        send_order(30'd20, 30'd0, SIDE_SELL);
        send_order(30'h2AAAAAAA, 30'h15555555, SIDE_BUY);
        send_order(30'h15555555, 30'h2AAAAAAA, SIDE_SELL);
        drain_results();
        for (int n = 0; n < 420; n++)
            send_order(pick_price(), pick_amount(), 1'($urandom));
        // rest a run of low buys, then sweep them with sells
        drain_results();
        for (int n = 0; n < 10; n++)
            send_order(30'd1, 30'($urandom_range(1, 9)), SIDE_BUY);
        for (int n = 0; n < 12; n++)
            send_order(30'd1, 30'($urandom_range(1, 40)), SIDE_SELL);
        drain_results();
        repeat (50) @(posedge clk);
        if (errors == 0 && books.pending.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+design
design/lobm_pkg.sv
design/lobm_cell.sv
design/lobm_book.sv
design/limit_order_book_matcher_unit.sv
tb/limit_order_book_matcher_unit_test.sv
